// File: hw/rtl/ordered_list_delete_transpose_assert.svh
// Assertion macros for the ordered list checker
`ifndef ORDERED_LIST_DELETE_TRANSPOSE_ASSERT_SVH
`define ORDERED_LIST_DELETE_TRANSPOSE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define OLT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("olt assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define OLT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("olt assertion failed");

`endif

// File: hw/rtl/olt_pkg.sv
// Types, codes and constants shared by the ordered list block
`default_nettype none
package olt_pkg;

	localparam int ID_W            = 7;
	localparam int DEF_MAX_ENTRIES = 64;
	localparam logic [ID_W-1:0] ENTRY_COUNT_RST = 7'd64;

	typedef enum logic [1:0] {
		REQ_REMOVE = 2'd0,
		REQ_MOVE   = 2'd1,
		REQ_READ   = 2'd2,
		REQ_LOAD   = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_EMPTY   = 2'd2
	} status_t;

	typedef struct packed {
		req_type_t       req_type;
		logic [ID_W-1:0] target_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] entry_id;
		status_t         status;
		logic            is_last;
	} rsp_t;

	// broadcast to every cell
	typedef struct packed {
		logic            load;
		logic            remove;
		logic            swap;
		logic            rotate;
		logic [ID_W-1:0] target;
	} cell_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/olt_cell.sv
// One list position: holds an id, compares it, takes a neighbor's id on command
`default_nettype none
module olt_cell import olt_pkg::*; #(
	parameter int LEN_W = 7,
	parameter int IDX   = 0
) (
	input  wire logic             clk,
	input  wire cell_ctl_t        ctl,
	input  wire logic [LEN_W-1:0] len,
	input  wire logic [LEN_W-1:0] pos,
	input  wire logic [ID_W-1:0]  prev_id,
	input  wire logic [ID_W-1:0]  next_id,
	input  wire logic [ID_W-1:0]  head_id,
	output logic      [ID_W-1:0]  id,
	output logic                  hit
);

	localparam logic [LEN_W-1:0] MY_POS  = LEN_W'(IDX);
	localparam logic [LEN_W-1:0] MY_NEXT = LEN_W'(IDX + 1);

	logic [ID_W-1:0] id_q;
	logic            in_list;
	logic            is_tail;

	assign in_list = MY_POS < len;
	assign is_tail = MY_NEXT == len;
	assign hit     = in_list && (id_q == ctl.target);
	assign id      = id_q;

	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			id_q <= ID_W'(IDX + 1);
		end else if (ctl.remove && MY_POS >= pos) begin
			id_q <= next_id;
		end else if (ctl.swap && MY_NEXT == pos) begin
			id_q <= next_id;
		end else if (ctl.swap && MY_POS == pos && IDX != 0) begin
			id_q <= prev_id;
		end else if (ctl.rotate && is_tail) begin
			// wrap the head around so the list is whole after a full pass
			id_q <= head_id;
		end else if (ctl.rotate && in_list) begin
			id_q <= next_id;
		end else begin
			id_q <= id_q;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/olt_enc.sv
// Turns the one-hot hit vector of the cell row into a position
`default_nettype none
module olt_enc #(
	parameter int N     = 64,
	parameter int LEN_W = 7
) (
	input  wire logic [N-1:0]     hit,
	output logic      [LEN_W-1:0] pos,
	output logic                  found
);

	// at most one cell hits, so an OR of the indexes is the position
	always_comb begin
		pos = '0;
		for (int i = 0; i < N; i++) begin
			pos = pos | (hit[i] ? LEN_W'(i) : '0);
		end
	end

	assign found = |hit;

endmodule
`default_nettype wire

// File: hw/rtl/ordered_list_delete_transpose.sv
// Top level: ordered id list with remove, transpose, read-out and load
//
// channel | direction | handshake               | payload
// request | in        | start high, busy low    | req (req_type, target_id)
// result  | out       | done high per result    | rsp (entry_id, status, is_last)
// config  | in        | cfg_we high             | cfg_data (entry_count)
//
// Load and any request on an empty list: result one cycle after accept.
// Remove and move: the cells compare, the hit is encoded and registered, then
// the cells from the hit on shift toward the head, or the hit cell and the one before it swap, all in the same cycle.
// Read: one result per cycle for list_length cycles, taken from the head
// cell while the row rotates once around.
// Reset empties the list and sets entry_count to 64; results cannot be held off.
`default_nettype none
module ordered_list_delete_transpose import olt_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire req_t            req,
	input  wire logic            cfg_we,
	input  wire logic [ID_W-1:0] cfg_data,
	output logic                 done,
	output rsp_t                 rsp
);

	localparam int LEN_W = $clog2(MAX_ENTRIES + 1);
	localparam int CNT_W = (LEN_W > ID_W) ? LEN_W : ID_W;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_APPLY = 3'b010,
		S_READ  = 3'b100
	} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  rd_cnt_q;
	logic [LEN_W-1:0]  pos_q;
	logic              found_q;
	req_type_t         op_q;
	logic [ID_W-1:0]   entry_count_q;
	logic              done_q;
	rsp_t              rsp_q;

	cell_ctl_t         ctl;
	logic              accept;
	logic [MAX_ENTRIES-1:0] hits;
	logic [ID_W-1:0]   ids [MAX_ENTRIES];
	logic [LEN_W-1:0]  pos_d;
	logic              found_d;
	logic [CNT_W-1:0]  cnt_ext;
	logic [LEN_W-1:0]  load_len;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;
	assign done   = done_q;
	assign rsp    = rsp_q;

	// clamp the load count to the row length
	assign cnt_ext  = CNT_W'(entry_count_q);
	assign load_len = (cnt_ext > CNT_W'(MAX_ENTRIES)) ? LEN_W'(MAX_ENTRIES) : LEN_W'(cnt_ext);

	always_comb begin
		ctl.load   = accept && req.req_type == REQ_LOAD;
		ctl.remove = state_q == S_APPLY && found_q && op_q == REQ_REMOVE;
		ctl.swap   = state_q == S_APPLY && found_q && op_q == REQ_MOVE;
		ctl.rotate = state_q == S_READ;
		ctl.target = req.target_id;
	end

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		logic [ID_W-1:0] prev_id;
		logic [ID_W-1:0] next_id;

		if (g == 0) begin : g_head
			assign prev_id = '0;
		end else begin : g_body
			assign prev_id = ids[g-1];
		end
		if (g == MAX_ENTRIES - 1) begin : g_tail
			assign next_id = '0;
		end else begin : g_mid
			assign next_id = ids[g+1];
		end

		olt_cell #(
			.LEN_W (LEN_W),
			.IDX   (g)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.len     (len_q),
			.pos     (pos_q),
			.prev_id (prev_id),
			.next_id (next_id),
			.head_id (ids[0]),
			.id      (ids[g]),
			.hit     (hits[g])
		);
	end

	olt_enc #(
		.N     (MAX_ENTRIES),
		.LEN_W (LEN_W)
	) u_enc (
		.hit   (hits),
		.pos   (pos_d),
		.found (found_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= ENTRY_COUNT_RST;
		end else if (cfg_we) begin
			entry_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			len_q    <= '0;
			rd_cnt_q <= '0;
			pos_q    <= '0;
			found_q  <= 1'b0;
			op_q     <= REQ_REMOVE;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (req.req_type == REQ_LOAD) begin
							len_q  <= load_len;
							done_q <= 1'b1;
						end else if (len_q == '0) begin
							done_q <= 1'b1;
						end else if (req.req_type == REQ_READ) begin
							rd_cnt_q <= len_q;
							state_q  <= S_READ;
						end else begin
							op_q    <= req.req_type;
							pos_q   <= pos_d;
							found_q <= found_d;
							state_q <= S_APPLY;
						end
					end
				end
				S_APPLY: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (found_q && op_q == REQ_REMOVE) begin
						len_q <= len_q - LEN_W'(1);
					end
				end
				S_READ: begin
					done_q   <= 1'b1;
					rd_cnt_q <= rd_cnt_q - LEN_W'(1);
					if (rd_cnt_q == LEN_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rsp_q.entry_id <= '0;
				rsp_q.is_last  <= 1'b1;
				rsp_q.status   <= (req.req_type != REQ_LOAD && len_q == '0) ? ST_EMPTY : ST_OK;
			end
			S_APPLY: begin
				rsp_q.entry_id <= '0;
				rsp_q.is_last  <= 1'b1;
				rsp_q.status   <= found_q ? ST_OK : ST_MISSING;
			end
			S_READ: begin
				rsp_q.entry_id <= ids[0];
				rsp_q.is_last  <= rd_cnt_q == LEN_W'(1);
				rsp_q.status   <= ST_OK;
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: hw/rtl/olt_checker.sv
// Port-level checks for the ordered list block, bound to the top level
`default_nettype none
`include "ordered_list_delete_transpose_assert.svh"
module olt_checker import olt_pkg::*; (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            start,
	input wire logic            busy,
	input wire logic            done,
	input wire rsp_t            rsp
);

	// an accepted item either answers at once or keeps the block busy
	`OLT_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy)
	// read-out results come back to back until the last one
	`OLT_ASSERT_NEXT(a_read_burst, done && !rsp.is_last, done)
	`OLT_ASSERT_NOW(a_burst_busy, done && !rsp.is_last, busy)
	// error results are single and carry no id
	`OLT_ASSERT_NOW(a_error_single, done && rsp.status != ST_OK, rsp.is_last && rsp.entry_id == '0)

endmodule

bind ordered_list_delete_transpose olt_checker u_olt_checker (.*);
`default_nettype wire
